@@ design/m4mul_pkg.sv @@
// ----------------------------------------------------------------------------
// m4mul_pkg
// Shared types and constants for the fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package m4mul_pkg;

  // Matrix dimension used when the top level is not overridden.
  localparam int DIM_DEFAULT = 4;

  // Q16.16 element format.
  localparam int VAL_W     = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int TERM_W    = PROD_W - FRAC_BITS;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Wait-counter value at which ST_WAIT hands over to ST_PUT.
  localparam logic WAIT_LAST = 1'b1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MAC,
    ST_WAIT,
    ST_PUT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;     // store one loaded element pair
    logic rd_en;     // read one operand pair into the multiplier
    logic first;     // this operand pair starts a new sum
    logic put;       // move the finished sum into the output register
    logic put_last;  // the sum being moved is the final element
  } dp_cmd_t;

endpackage

@@ design/m4mul_in_if.sv @@
// ----------------------------------------------------------------------------
// m4mul_in_if
// Operand channel: one left and one right matrix element per beat.
// ----------------------------------------------------------------------------
interface m4mul_in_if;
  import m4mul_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] left_value;
  logic signed [VAL_W-1:0] right_value;

  modport source (output valid, output left_value, output right_value, input ready);
  modport sink (input valid, input left_value, input right_value, output ready);

endinterface

@@ design/m4mul_out_if.sv @@
// ----------------------------------------------------------------------------
// m4mul_out_if
// Result channel: one product element per beat, last element flagged.
// ----------------------------------------------------------------------------
interface m4mul_out_if;
  import m4mul_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] product_value;
  logic                    last_element;

  modport source (output valid, output product_value, output last_element, input ready);
  modport sink (input valid, input product_value, input last_element, output ready);

endinterface

@@ design/matrix4_multiply.sv @@
// ----------------------------------------------------------------------------
// matrix4_multiply
// Fixed-point Q16.16 DIM x DIM matrix product with saturated results.
// ----------------------------------------------------------------------------
//  Channel   Dir   Beat carries                        Accepted when
//  operand   in    left_value, right_value             valid && ready
//  result    out   product_value, last_element         valid && ready
//
//  Loading takes one beat per cycle for DIM*DIM beats while valid is held.
//  Each result element then runs on the single shared multiplier:
//  DIM operand reads, pipeline fill in ST_WAIT, one transfer.
//  No new set is loaded until the last result of a set has been put.
//  A stalled result beat holds in the output register; the next sum waits.
//  Reset clears the control state only; the operand memories are not cleared.
// ----------------------------------------------------------------------------
module matrix4_multiply #(
  parameter int DIM = m4mul_pkg::DIM_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  m4mul_in_if.sink     operand,
  m4mul_out_if.source  result
);
  import m4mul_pkg::*;

  localparam int ADDR_W = $clog2(DIM * DIM);

  dp_cmd_t           cmd;
  logic [ADDR_W-1:0] wr_addr, left_addr, right_addr;
  logic              out_free;

  m4mul_ctrl #(.DIM(DIM)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (operand.valid),
    .in_ready   (operand.ready),
    .out_free   (out_free),
    .cmd        (cmd),
    .wr_addr    (wr_addr),
    .left_addr  (left_addr),
    .right_addr (right_addr)
  );

  m4mul_dp #(.DIM(DIM)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .wr_addr     (wr_addr),
    .left_addr   (left_addr),
    .right_addr  (right_addr),
    .left_value  (operand.left_value),
    .right_value (operand.right_value),
    .out_free    (out_free),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_value   (result.product_value),
    .out_last    (result.last_element)
  );

endmodule

@@ design/m4mul_ctrl.sv @@
// ----------------------------------------------------------------------------
// m4mul_ctrl
// Sequencer: counts loaded pairs, then walks col, row and term index,
// issues one multiply-accumulate per cycle while in ST_MAC and puts each sum.
// ----------------------------------------------------------------------------
module m4mul_ctrl #(
  parameter int DIM = m4mul_pkg::DIM_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              out_free,
  output m4mul_pkg::dp_cmd_t                cmd,
  output logic [$clog2(DIM*DIM)-1:0]        wr_addr,
  output logic [$clog2(DIM*DIM)-1:0]        left_addr,
  output logic [$clog2(DIM*DIM)-1:0]        right_addr
);
  import m4mul_pkg::*;

  localparam int ELEMS  = DIM * DIM;
  localparam int ADDR_W = $clog2(ELEMS);
  localparam int IDX_W  = $clog2(DIM);
  localparam logic [ADDR_W-1:0] LOAD_LAST = ADDR_W'(ELEMS - 1);
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(DIM - 1);
  localparam logic [ADDR_W-1:0] DIM_A     = ADDR_W'(DIM);

  ctrl_state_t       state, state_next;
  logic [ADDR_W-1:0] load_count;
  logic [IDX_W-1:0]  col, row, term;
  logic              wait_cnt;
  logic              accept;
  logic              set_done;
  logic              elem_last;

  assign accept    = in_valid && in_ready;
  assign set_done  = (load_count == LOAD_LAST);
  assign elem_last = (col == IDX_LAST) && (row == IDX_LAST);
  assign wr_addr   = load_count;
  assign left_addr  = ADDR_W'(ADDR_W'(term) * DIM_A + ADDR_W'(row));
  assign right_addr = ADDR_W'(ADDR_W'(col) * DIM_A + ADDR_W'(term));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (accept && set_done) state_next = ST_MAC;
      end
      ST_MAC: begin
        if (term == IDX_LAST) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (wait_cnt == WAIT_LAST) state_next = ST_PUT;
      end
      ST_PUT: begin
        if (out_free) state_next = elem_last ? ST_LOAD : ST_MAC;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state)
      ST_LOAD: begin
        // Ready is high throughout loading, so a valid beat is accepted.
        in_ready  = 1'b1;
        cmd.wr_en = in_valid;
      end
      ST_MAC: begin
        cmd.rd_en = 1'b1;
        cmd.first = (term == '0);
      end
      ST_WAIT: begin
      end
      ST_PUT: begin
        cmd.put      = out_free;
        cmd.put_last = elem_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      col        <= '0;
      row        <= '0;
      term       <= '0;
      wait_cnt   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            load_count <= set_done ? '0 : load_count + 1'b1;
            col        <= '0;
            row        <= '0;
            term       <= '0;
          end
        end
        ST_MAC: begin
          term     <= (term == IDX_LAST) ? '0 : term + 1'b1;
          wait_cnt <= 1'b0;
        end
        ST_WAIT: begin
          wait_cnt <= ~wait_cnt;
        end
        ST_PUT: begin
          // Results leave in flat order, row running fastest.
          if (out_free) begin
            if (row == IDX_LAST) begin
              row <= '0;
              col <= col + 1'b1;
            end else begin
              row <= row + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ design/m4mul_dp.sv @@
// ----------------------------------------------------------------------------
// m4mul_dp
// Datapath: operand memories, one shared 32x32 multiplier, a wide
// accumulator, saturation and the output register.
// ----------------------------------------------------------------------------
module m4mul_dp #(
  parameter int DIM = m4mul_pkg::DIM_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  m4mul_pkg::dp_cmd_t                cmd,
  input  logic [$clog2(DIM*DIM)-1:0]        wr_addr,
  input  logic [$clog2(DIM*DIM)-1:0]        left_addr,
  input  logic [$clog2(DIM*DIM)-1:0]        right_addr,
  input  logic signed [m4mul_pkg::VAL_W-1:0] left_value,
  input  logic signed [m4mul_pkg::VAL_W-1:0] right_value,
  output logic                              out_free,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [m4mul_pkg::VAL_W-1:0] out_value,
  output logic                              out_last
);
  import m4mul_pkg::*;

  localparam int ELEMS = DIM * DIM;
  localparam int ACC_W = TERM_W + $clog2(DIM) + 1;

  logic signed [VAL_W-1:0]  left_mem  [ELEMS];
  logic signed [VAL_W-1:0]  right_mem [ELEMS];
  logic signed [VAL_W-1:0]  left_rd, right_rd;
  logic                     rd_valid, rd_first;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid, prod_first;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  term;
  logic signed [VAL_W-1:0]  sat_value;
  logic                     acc_fits;

  // Operand stores: one write port for loading, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      left_mem[wr_addr]  <= left_value;
      right_mem[wr_addr] <= right_value;
    end
    if (cmd.rd_en) begin
      left_rd  <= left_mem[left_addr];
      right_rd <= right_mem[right_addr];
    end
  end

  always_ff @(posedge clk) begin
    prod <= left_rd * right_rd;
  end

  // Dropping the low 16 bits of the two's complement product floors it.
  assign term = {{(ACC_W-TERM_W){prod[PROD_W-1]}}, prod[PROD_W-1:FRAC_BITS]};

  always_ff @(posedge clk) begin
    if (prod_valid) begin
      acc <= prod_first ? term : acc + term;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      rd_first   <= 1'b0;
      prod_valid <= 1'b0;
      prod_first <= 1'b0;
    end else begin
      rd_valid   <= cmd.rd_en;
      rd_first   <= cmd.first;
      prod_valid <= rd_valid;
      prod_first <= rd_first;
    end
  end

  // The sum fits when every bit above bit 31 copies the sign bit.
  assign acc_fits  = (acc[ACC_W-1:VAL_W-1] == '0) || (acc[ACC_W-1:VAL_W-1] == '1);
  assign sat_value = acc_fits ? acc[VAL_W-1:0] : (acc[ACC_W-1] ? VAL_MIN : VAL_MAX);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      out_value <= sat_value;
      out_last  <= cmd.put_last;
    end
  end

endmodule

@@ tb/sv/m4mul_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4mul_tb_pkg
// Scoreboard for the Q16.16 matrix multiplier. It collects each set of loaded
// element pairs and, on the last pair of a set, predicts the product elements.
// Result beats are then checked in order against those predictions.
// ----------------------------------------------------------------------------
package m4mul_tb_pkg;
  import m4mul_pkg::*;

  localparam int ELEMS = DIM_DEFAULT * DIM_DEFAULT;

  typedef logic signed [VAL_W-1:0] q16_t;

  typedef struct packed {
    q16_t value;
    logic last;
  } product_beat_t;

  class product_scoreboard;
    q16_t            left_mem[ELEMS];
    q16_t            right_mem[ELEMS];
    int unsigned     fill_count;
    product_beat_t   product_queue[$];
    int unsigned     errors;
    int unsigned     pairs_in;
    int unsigned     products_seen;
    int unsigned     sets_done;
    int unsigned     clamped;

    function new();
      fill_count    = 0;
      errors        = 0;
      pairs_in      = 0;
      products_seen = 0;
      sets_done     = 0;
      clamped       = 0;
    endfunction

    function int unsigned pending();
      return product_queue.size();
    endfunction

    // Each term is floored to Q16.16 before it joins the wide sum, and only
    // the finished sum is clamped to 32 bits.
    function q16_t dot_product(int unsigned col, int unsigned row);
      logic signed [PROD_W-1:0] a;
      logic signed [PROD_W-1:0] b;
      logic signed [PROD_W-1:0] sum;
      int unsigned i;
      sum = '0;
      for (i = 0; i < DIM_DEFAULT; i++) begin
        a = right_mem[col * DIM_DEFAULT + i];
        b = left_mem[i * DIM_DEFAULT + row];
        sum += (a * b) >>> FRAC_BITS;
      end
      if (sum > VAL_MAX) begin
        clamped++;
        return VAL_MAX;
      end
      if (sum < VAL_MIN) begin
        clamped++;
        return VAL_MIN;
      end
      return sum[VAL_W-1:0];
    endfunction

    function void note_pair(q16_t left_value, q16_t right_value);
      int unsigned col;
      int unsigned row;
      product_beat_t beat;
      left_mem[fill_count]  = left_value;
      right_mem[fill_count] = right_value;
      fill_count++;
      pairs_in++;
      if (fill_count == ELEMS) begin
        fill_count = 0;
        sets_done++;
        for (col = 0; col < DIM_DEFAULT; col++) begin
          for (row = 0; row < DIM_DEFAULT; row++) begin
            beat.value = dot_product(col, row);
            beat.last  = (col * DIM_DEFAULT + row == ELEMS - 1);
            product_queue.push_back(beat);
          end
        end
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_product(q16_t value, logic last);
      product_beat_t want;
      products_seen++;
      if (product_queue.size() == 0) begin
        report($sformatf("result beat %0d arrived with nothing outstanding", products_seen));
        return;
      end
      want = product_queue.pop_front();
      if (value !== want.value) begin
        report($sformatf("result beat %0d: product_value %0d, predicted %0d",
                         products_seen, value, want.value));
      end
      if (last !== want.last) begin
        report($sformatf("result beat %0d: last_element %b, predicted %b",
                         products_seen, last, want.last));
      end
    endtask
  endclass

endpackage

@@ tb/sv/tb_matrix4_multiply.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix4_multiply
// Loads sets of element pairs into the matrix multiplier: one set of corner
// values, then random sets of full-range, small, corner and mixed values.
// Sender gaps and receiver stalls change from phase to phase, and every
// result beat is compared with the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_matrix4_multiply;
  import m4mul_pkg::*;
  import m4mul_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 4 * (DIM_DEFAULT + 3);
  localparam int RANDOM_SETS = 24;
  localparam int SETS_PER_PHASE = 6;

  typedef enum int {
    FILL_FULL,
    FILL_SMALL,
    FILL_CORNER,
    FILL_MIXED
  } fill_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned cycle_count   = 0;

  q16_t corner_values [16] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
    32'hFFFF_8000, 32'h7FFF_0000, 32'h8000_0001, 32'h0000_FFFF,
    32'h0100_0000, 32'hFF00_0000, 32'h0000_0002, 32'h5555_5555
  };

  product_scoreboard sb = new();

  m4mul_in_if  operand_ch ();
  m4mul_out_if result_ch ();

  matrix4_multiply dut (
    .clk     (clk),
    .rst     (rst),
    .operand (operand_ch),
    .result  (result_ch)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d result beats outstanding.",
               cycle_count, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        sb.check_product(result_ch.product_value, result_ch.last_element);
      end
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic q16_t pick_value(fill_mode_t mode);
    logic [19:0] mag;
    fill_mode_t  sub;
    sub = mode;
    if (sub == FILL_MIXED) begin
      sub = fill_mode_t'($urandom_range(FILL_CORNER));
    end
    case (sub)
      FILL_FULL: begin
        return $urandom;
      end
      FILL_SMALL: begin
        // Roughly -8.0 .. 8.0, so sums mostly stay inside the 32-bit range.
        mag = 20'($urandom);
        return {{(VAL_W - 20){mag[19]}}, mag};
      end
      default: begin
        return corner_values[$urandom_range(15)];
      end
    endcase
  endfunction

  // Valid stays high between back-to-back beats; it only drops for a gap.
  task automatic send_pair(input q16_t left_value, input q16_t right_value);
    while ($urandom_range(99) < send_idle_pct) begin
      operand_ch.valid <= 1'b0;
      @(posedge clk);
    end
    operand_ch.valid       <= 1'b1;
    operand_ch.left_value  <= left_value;
    operand_ch.right_value <= right_value;
    @(posedge clk);
    while (!operand_ch.ready) @(posedge clk);
    sb.note_pair(left_value, right_value);
  endtask

  task automatic send_set(input fill_mode_t mode);
    int k;
    for (k = 0; k < ELEMS; k++) begin
      send_pair(pick_value(mode), pick_value(mode));
    end
  endtask

  task automatic hold_until_drained();
    operand_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int k;
    int s;
    operand_ch.valid       = 1'b0;
    operand_ch.left_value  = '0;
    operand_ch.right_value = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Corner set: both extremes, zero, +/-1 LSB, +/-1.0 and +/-0.5. The mix
    // saturates in both directions and floors negative products.
    for (k = 0; k < ELEMS; k++) begin
      send_pair(corner_values[k], corner_values[(k * 5 + 3) % 16]);
    end

    for (s = 0; s < RANDOM_SETS; s++) begin
      if (s % SETS_PER_PHASE == 0) begin
        case (s / SETS_PER_PHASE)
          0: begin
            send_idle_pct = 0;
            stall_pct     = 0;
          end
          1: begin
            // Let the whole pipeline empty once before gaps start.
            hold_until_drained();
            send_idle_pct = 46;
            stall_pct     = 0;
          end
          2: begin
            send_idle_pct = 0;
            stall_pct     = 46;
          end
          default: begin
            send_idle_pct = 26;
            stall_pct     = 26;
          end
        endcase
      end
      send_set(fill_mode_t'($urandom_range(FILL_MIXED)));
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d operand beats in %0d sets; checked %0d result beats, %0d of them clamped.",
             sb.pairs_in, sb.sets_done, sb.products_seen, sb.clamped);
    $display("Phases ran with no gaps, sender gaps, receiver stalls, and both together.");
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
